/* rtl/rtdrt_pkg.sv */
// ----------------------------------------------------------------------------
// rtdrt_pkg
// Constants for the PT1000 resistance to temperature converter: radicand
// coefficients, square root width and the reciprocal used for the final divide.
// ----------------------------------------------------------------------------
package rtdrt_pkg;

  localparam int unsigned ResW  = 20;
  localparam int unsigned TempW = 19;

  // radicand d = RadBase - RadSlope * r, then m = 409600 * d = (25 * d) << 14
  localparam int unsigned SlopeW   = 18;
  localparam int unsigned DW       = 39;
  localparam int unsigned D25W     = 44;
  localparam int unsigned SqShift  = 14;
  localparam int unsigned RadW     = D25W + SqShift;
  localparam int unsigned RootW    = RadW / 2;

  localparam logic [SlopeW-1:0] RadSlope = 18'd231000;
  localparam logic [DW-1:0]     RadBase  = 39'd450171107584;

  // numerator offset biased by 462 * 131072 so it never goes negative
  localparam logic [RootW-1:0]  NumOff   = 29'd460765415;
  localparam int unsigned       HalfW    = RootW - 1;

  // floor(x / 231) = (x * RecipM) >> RecipShift, exact for x below 2^28
  localparam int unsigned       RecipW     = 29;
  localparam int unsigned       RecipShift = 36;
  localparam logic [RecipW-1:0] RecipM     = 29'd297486913;
  localparam int unsigned       ProdW      = HalfW + RecipW;
  localparam int unsigned       QuotW      = ProdW - RecipShift;
  localparam logic [QuotW-1:0]  TempBias   = 21'd131072;

endpackage

/* rtl/rtdrt_sqrt_pipe.sv */
// ----------------------------------------------------------------------------
// rtdrt_sqrt_pipe
// Pipelined integer square root, one result bit per register stage. Gives
// the floor root and a flag that tells whether the radicand was a square.
// ----------------------------------------------------------------------------
module rtdrt_sqrt_pipe #(
  parameter int unsigned RadW = 58
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [RadW-1:0]     rad_i,
  output logic                valid_o,
  output logic [RadW/2-1:0]   root_o,
  output logic                exact_o
);

  localparam int unsigned RootW = RadW / 2;
  localparam int unsigned RemW  = RootW + 1;

  logic [RootW-1:0] root_q [RootW];
  logic [RemW-1:0]  rem_q  [RootW];
  logic [RadW-1:0]  rad_q  [RootW-1];
  logic             vld_q  [RootW];

  for (genvar s = 0; s < RootW; s++) begin : g_stage
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [RadW-1:0]  rad_in;
    logic             vld_in;
    logic [RemW+1:0]  cat;
    logic [RemW+2:0]  diff;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    // bring down the next two radicand bits and try 4*root + 1
    assign cat  = {rem_in, rad_in[RadW-1 -: 2]};
    assign diff = {1'b0, cat} - {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (diff[RemW+2]) begin
          rem_q[s]  <= cat[RemW-1:0];
          root_q[s] <= {root_in[RootW-2:0], 1'b0};
        end else begin
          rem_q[s]  <= diff[RemW-1:0];
          root_q[s] <= {root_in[RootW-2:0], 1'b1};
        end
      end
    end

    if (s < RootW - 1) begin : g_rad
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rad_q[s] <= {rad_in[RadW-3:0], 2'b00};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end
  end

  assign valid_o = vld_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign exact_o = (rem_q[RootW-1] == '0);

endmodule

/* rtl/rtd_resistance_to_temperature.sv */
// ----------------------------------------------------------------------------
// rtd_resistance_to_temperature
// PT1000 resistance to temperature, inverse Callendar-Van Dusen (quadratic).
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_ready_o   resistance_i  [19:0] u, ohm q.8
//   out       output     out_valid_o / out_ready_i temperature_o [18:0] s, degC q.8
//
// one reading per cycle sustained while results are taken; a reading passes from the
// accepting edge to out_valid_o through 36 stages: 4 radicand, 29 square root, 3 divide
// the whole pipeline advances together; it holds while the output register
// carries a result that is not taken, and in_ready_o drops only then
// reset clears the valid bits only, the block keeps no other state
// ----------------------------------------------------------------------------
module rtd_resistance_to_temperature
  import rtdrt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ResW-1:0]  resistance_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [TempW-1:0] temperature_o
);

  logic adv;

  logic                      v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic [ResW-1:0]           res_q;
  logic [ResW+SlopeW-1:0]    slope_q;
  logic [DW-1:0]             d_q;
  logic [D25W-1:0]           d25_q;
  logic [HalfW-1:0]          uhalf_q;
  logic [ProdW-1:0]          prod_q;
  logic [TempW-1:0]          temp_q;

  logic                      sq_valid;
  logic [RootW-1:0]          sq_root;
  logic                      sq_exact;

  logic [D25W-1:0]           d25_d;
  logic [RootW-1:0]          ceil_root;
  logic [RootW-1:0]          num;
  logic [QuotW-1:0]          quot;
  logic [QuotW-1:0]          temp_d;

  assign adv        = !v6_q || out_ready_i;
  assign in_ready_o = adv;

  // 25 * d by shift and add
  assign d25_d = {{(D25W-DW-4){1'b0}}, d_q, 4'b0000}
               + {{(D25W-DW-3){1'b0}}, d_q, 3'b000}
               + {{(D25W-DW){1'b0}}, d_q};

  // ceiling of the root, then the biased numerator
  assign ceil_root = sq_root + {{(RootW-1){1'b0}}, !sq_exact};
  assign num       = NumOff - ceil_root;

  assign quot   = prod_q[ProdW-1 -: QuotW];
  assign temp_d = quot - TempBias;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q   <= resistance_i;
      slope_q <= RadSlope * res_q;
      d_q     <= RadBase - {1'b0, slope_q};
      d25_q   <= d25_d;
      uhalf_q <= num[RootW-1:1];
      prod_q  <= uhalf_q * RecipM;
      temp_q  <= temp_d[TempW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= sq_valid;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  rtdrt_sqrt_pipe #(
    .RadW(RadW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v3_q),
    .rad_i   ({d25_q, {SqShift{1'b0}}}),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .exact_o (sq_exact)
  );

  assign out_valid_o   = v6_q;
  assign temperature_o = temp_q;

  // a result not taken stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(temperature_o))
    else $error("result changed while stalled");

  // a stall freezes the valid bits of this module and the square root output valid
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable({v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q}) && $stable(sq_valid))
    else $error("pipeline moved during stall");

  // the biased numerator never wraps
  a_root_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_valid |-> (ceil_root < NumOff))
    else $error("square root out of range");

endmodule
